// ===== hw/rtl/hstcm_pkg.sv =====
// ----------------------------------------------------------------------------
// hstcm_pkg
// shared types, codes and helper functions for the trained hsv color mask
// ----------------------------------------------------------------------------
package hstcm_pkg;

   // operation codes
   localparam logic [1:0] OP_PIXEL      = 2'd0;
   localparam logic [1:0] OP_SAMPLE     = 2'd1;
   localparam logic [1:0] OP_CLEAR_RED  = 2'd2;
   localparam logic [1:0] OP_CLEAR_BLUE = 2'd3;

   // sample outcome codes
   localparam logic [1:0] OUTCOME_NONE     = 2'd0;
   localparam logic [1:0] OUTCOME_RED      = 2'd1;
   localparam logic [1:0] OUTCOME_BLUE     = 2'd2;
   localparam logic [1:0] OUTCOME_REJECTED = 2'd3;

   // register indexes
   localparam logic [1:0] REG_RED_HUE_MARGIN    = 2'd0;
   localparam logic [1:0] REG_BLUE_HUE_MARGIN   = 2'd1;
   localparam logic [1:0] REG_SATURATION_MARGIN = 2'd2;
   localparam logic [1:0] REG_BRIGHTNESS_MARGIN = 2'd3;

   // register reset values
   localparam logic [6:0] RED_HUE_MARGIN_RST    = 7'd5;
   localparam logic [6:0] BLUE_HUE_MARGIN_RST   = 7'd10;
   localparam logic [7:0] SATURATION_MARGIN_RST = 8'd20;
   localparam logic [7:0] BRIGHTNESS_MARGIN_RST = 8'd20;

   // channel limits and training hue windows
   localparam logic [7:0] HUE_TOP       = 8'd180;
   localparam logic [7:0] CHAN_TOP      = 8'd255;
   localparam logic [7:0] RED_LOW_TOP   = 8'd20;
   localparam logic [7:0] RED_HIGH_BASE = 8'd150;
   localparam logic [7:0] BLUE_BASE     = 8'd90;
   localparam logic [7:0] BLUE_TOP      = 8'd140;

   typedef struct packed {
      logic [7:0] hue;
      logic [7:0] saturation;
      logic [7:0] brightness;
   } pixel_type;

   typedef struct packed {
      logic add;
      logic clear;
   } class_upd_type;

   typedef struct packed {
      logic [6:0] hue_margin;
      logic [7:0] saturation_margin;
      logic [7:0] brightness_margin;
   } margins_type;

   // lo - margin (floored at 0) <= x <= hi + margin (capped at top)
   function automatic logic in_widened(input logic [7:0] x, input logic [7:0] lo,
                                       input logic [7:0] hi, input logic [7:0] margin,
                                       input logic [7:0] top);
      logic [7:0] low;
      logic [8:0] high_sum;
      logic [7:0] high;
      low      = (lo > margin) ? (lo - margin) : 8'd0;
      high_sum = {1'b0, hi} + {1'b0, margin};
      high     = (high_sum > {1'b0, top}) ? top : high_sum[7:0];
      return (x >= low) && (x <= high);
   endfunction

   // which class a training hue joins
   function automatic logic [1:0] sample_outcome(input logic [7:0] hue);
      logic [1:0] res;
      priority if ((hue <= RED_LOW_TOP) || ((hue >= RED_HIGH_BASE) && (hue <= HUE_TOP))) begin
         res = OUTCOME_RED;
      end else if ((hue >= BLUE_BASE) && (hue <= BLUE_TOP)) begin
         res = OUTCOME_BLUE;
      end else begin
         res = OUTCOME_REJECTED;
      end
      return res;
   endfunction

endpackage

// ===== hw/rtl/hstcm_if.sv =====
// ----------------------------------------------------------------------------
// hstcm_req_if / hstcm_rsp_if
// valid/ready channels for incoming items and outgoing results
// ----------------------------------------------------------------------------
interface hstcm_req_if;
   logic       valid;
   logic       ready;
   logic [1:0] operation;
   logic [7:0] hue;
   logic [7:0] saturation;
   logic [7:0] brightness;

   modport source (output valid, output operation, output hue, output saturation,
                   output brightness, input ready);
   modport sink   (input valid, input operation, input hue, input saturation,
                   input brightness, output ready);
endinterface

interface hstcm_rsp_if;
   logic       valid;
   logic       ready;
   logic       red_match;
   logic       blue_match;
   logic [1:0] sample_outcome;

   modport source (output valid, output red_match, output blue_match,
                   output sample_outcome, input ready);
   modport sink   (input valid, input red_match, input blue_match,
                   input sample_outcome, output ready);
endinterface

// ===== hw/rtl/hstcm_class.sv =====
// ----------------------------------------------------------------------------
// hstcm_class
// per-class running min/max bounds with widened-bounds pixel test
// ----------------------------------------------------------------------------
module hstcm_class (
   input  logic                   clock,
   input  logic                   reset,
   input  hstcm_pkg::class_upd_type upd,
   input  hstcm_pkg::pixel_type   pix,
   input  hstcm_pkg::margins_type margins,
   output logic                   match,
   output logic                   has_samples
);

   logic [7:0] hue_lo_ff, hue_hi_ff, sat_lo_ff, sat_hi_ff, val_lo_ff, val_hi_ff;
   logic [7:0] hue_lo_in, hue_hi_in, sat_lo_in, sat_hi_in, val_lo_in, val_hi_in;
   logic       has_ff, has_in;

   always_comb begin
      hue_lo_in = hue_lo_ff;
      hue_hi_in = hue_hi_ff;
      sat_lo_in = sat_lo_ff;
      sat_hi_in = sat_hi_ff;
      val_lo_in = val_lo_ff;
      val_hi_in = val_hi_ff;
      has_in    = has_ff;
      if (upd.clear) begin
         hue_lo_in = 8'hFF;
         hue_hi_in = 8'h00;
         sat_lo_in = 8'hFF;
         sat_hi_in = 8'h00;
         val_lo_in = 8'hFF;
         val_hi_in = 8'h00;
         has_in    = 1'b0;
      end else if (upd.add) begin
         if (pix.hue < hue_lo_ff)        hue_lo_in = pix.hue;
         if (pix.hue > hue_hi_ff)        hue_hi_in = pix.hue;
         if (pix.saturation < sat_lo_ff) sat_lo_in = pix.saturation;
         if (pix.saturation > sat_hi_ff) sat_hi_in = pix.saturation;
         if (pix.brightness < val_lo_ff) val_lo_in = pix.brightness;
         if (pix.brightness > val_hi_ff) val_hi_in = pix.brightness;
         has_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hue_lo_ff <= 8'hFF;
         hue_hi_ff <= 8'h00;
         sat_lo_ff <= 8'hFF;
         sat_hi_ff <= 8'h00;
         val_lo_ff <= 8'hFF;
         val_hi_ff <= 8'h00;
         has_ff    <= 1'b0;
      end else begin
         hue_lo_ff <= hue_lo_in;
         hue_hi_ff <= hue_hi_in;
         sat_lo_ff <= sat_lo_in;
         sat_hi_ff <= sat_hi_in;
         val_lo_ff <= val_lo_in;
         val_hi_ff <= val_hi_in;
         has_ff    <= has_in;
      end
   end

   assign match = has_ff
      && hstcm_pkg::in_widened(pix.hue, hue_lo_ff, hue_hi_ff,
                               {1'b0, margins.hue_margin}, hstcm_pkg::HUE_TOP)
      && hstcm_pkg::in_widened(pix.saturation, sat_lo_ff, sat_hi_ff,
                               margins.saturation_margin, hstcm_pkg::CHAN_TOP)
      && hstcm_pkg::in_widened(pix.brightness, val_lo_ff, val_hi_ff,
                               margins.brightness_margin, hstcm_pkg::CHAN_TOP);

   assign has_samples = has_ff;

endmodule

// ===== hw/rtl/hsv_sample_trained_color_mask_core.sv =====
// ----------------------------------------------------------------------------
// hsv_sample_trained_color_mask_core
// red/blue hsv color mask whose class bounds are learned from samples
// ----------------------------------------------------------------------------
//
//  channel  | dir | handshake     | payload
//  ---------+-----+---------------+-----------------------------------------
//  req_ch   | in  | valid/ready   | operation, hue, saturation, brightness
//  rsp_ch   | out | valid/ready   | red_match, blue_match, sample_outcome
//  csr_*    | in  | csr_we only   | csr_index (2b), csr_wdata (8b)
//
//  one transaction per clock sustained while rsp_ch is ready; a request that
//  is taken goes into the input register, is executed into the result
//  register and is offered on rsp_ch from there
//  class bounds are read and updated in the same stage, so back-to-back
//  samples and pixels always see the latest training
//  reset (synchronous) empties both classes and restores the margin defaults
//  a stalled result holds; the input stage keeps one transaction behind it
//
module hsv_sample_trained_color_mask_core (
   input  logic       clock,
   input  logic       reset,
   hstcm_req_if.sink  req_ch,
   hstcm_rsp_if.source rsp_ch,
   input  logic       csr_we,
   input  logic [1:0] csr_index,
   input  logic [7:0] csr_wdata
);

   // margin registers
   logic [6:0] red_hue_margin_ff, blue_hue_margin_ff;
   logic [7:0] sat_margin_ff, val_margin_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         red_hue_margin_ff  <= hstcm_pkg::RED_HUE_MARGIN_RST;
         blue_hue_margin_ff <= hstcm_pkg::BLUE_HUE_MARGIN_RST;
         sat_margin_ff      <= hstcm_pkg::SATURATION_MARGIN_RST;
         val_margin_ff      <= hstcm_pkg::BRIGHTNESS_MARGIN_RST;
      end else if (csr_we) begin
         unique case (csr_index)
            hstcm_pkg::REG_RED_HUE_MARGIN:    red_hue_margin_ff  <= csr_wdata[6:0];
            hstcm_pkg::REG_BLUE_HUE_MARGIN:   blue_hue_margin_ff <= csr_wdata[6:0];
            hstcm_pkg::REG_SATURATION_MARGIN: sat_margin_ff      <= csr_wdata;
            hstcm_pkg::REG_BRIGHTNESS_MARGIN: val_margin_ff      <= csr_wdata;
            default: ;
         endcase
      end
   end

   // input register stage
   logic                 s1_valid_ff, s1_valid_in;
   logic [1:0]           s1_op_ff;
   hstcm_pkg::pixel_type s1_pix_ff;

   // result register stage
   logic       out_valid_ff, out_valid_in;
   logic       out_red_ff, out_blue_ff;
   logic [1:0] out_outcome_ff;

   logic advance;   // s1 moves into the result register
   logic fire;      // s1 holds a transaction that is being executed now
   logic req_take;

   assign advance  = !out_valid_ff || rsp_ch.ready;
   assign fire     = s1_valid_ff && advance;
   assign req_take = req_ch.valid && req_ch.ready;

   assign req_ch.ready = !s1_valid_ff || advance;

   assign s1_valid_in  = req_take ? 1'b1 : (fire ? 1'b0 : s1_valid_ff);
   assign out_valid_in = fire ? 1'b1 : (rsp_ch.ready ? 1'b0 : out_valid_ff);

   // decode of the executing transaction
   logic       is_pixel;
   logic       is_sample;
   logic [1:0] outcome;

   assign is_pixel  = (s1_op_ff == hstcm_pkg::OP_PIXEL);
   assign is_sample = (s1_op_ff == hstcm_pkg::OP_SAMPLE);
   assign outcome   = is_sample ? hstcm_pkg::sample_outcome(s1_pix_ff.hue)
                                : hstcm_pkg::OUTCOME_NONE;

   hstcm_pkg::class_upd_type red_upd, blue_upd;
   hstcm_pkg::margins_type   red_margins, blue_margins;
   logic red_match, blue_match, red_has, blue_has;

   assign red_upd.add    = fire && (outcome == hstcm_pkg::OUTCOME_RED);
   assign red_upd.clear  = fire && (s1_op_ff == hstcm_pkg::OP_CLEAR_RED);
   assign blue_upd.add   = fire && (outcome == hstcm_pkg::OUTCOME_BLUE);
   assign blue_upd.clear = fire && (s1_op_ff == hstcm_pkg::OP_CLEAR_BLUE);

   assign red_margins  = '{hue_margin: red_hue_margin_ff,
                           saturation_margin: sat_margin_ff,
                           brightness_margin: val_margin_ff};
   assign blue_margins = '{hue_margin: blue_hue_margin_ff,
                           saturation_margin: sat_margin_ff,
                           brightness_margin: val_margin_ff};

   hstcm_class u_red (
      .clock       (clock),
      .reset       (reset),
      .upd         (red_upd),
      .pix         (s1_pix_ff),
      .margins     (red_margins),
      .match       (red_match),
      .has_samples (red_has)
   );

   hstcm_class u_blue (
      .clock       (clock),
      .reset       (reset),
      .upd         (blue_upd),
      .pix         (s1_pix_ff),
      .margins     (blue_margins),
      .match       (blue_match),
      .has_samples (blue_has)
   );

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (req_take) begin
         s1_op_ff             <= req_ch.operation;
         s1_pix_ff.hue        <= req_ch.hue;
         s1_pix_ff.saturation <= req_ch.saturation;
         s1_pix_ff.brightness <= req_ch.brightness;
      end
      if (fire) begin
         out_red_ff     <= is_pixel && red_match;
         out_blue_ff    <= is_pixel && blue_match;
         out_outcome_ff <= outcome;
      end
   end

   assign rsp_ch.valid          = out_valid_ff;
   assign rsp_ch.red_match      = out_red_ff;
   assign rsp_ch.blue_match     = out_blue_ff;
   assign rsp_ch.sample_outcome = out_outcome_ff;

   // a clear leaves the class empty
   a_red_clear: assert property (@(posedge clock) disable iff (reset)
      red_upd.clear |=> !red_has)
      else $error("red class not empty after clear");

   a_blue_add: assert property (@(posedge clock) disable iff (reset)
      blue_upd.add |=> blue_has)
      else $error("blue class empty after sample");

   // sample results never carry a match
   a_no_match_on_sample: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && (out_outcome_ff != hstcm_pkg::OUTCOME_NONE))
         |-> (!out_red_ff && !out_blue_ff))
      else $error("match flagged on a sample result");

   // a waiting transaction in s1 is never overwritten
   a_s1_hold: assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff && !advance) |-> !req_ch.ready)
      else $error("input stage overwrite while stalled");

endmodule

// ===== tb/hsv_sample_trained_color_mask_core_test.sv =====
// ----------------------------------------------------------------------------
// hsv_sample_trained_color_mask_core_test
// self-checking bench for the sample-trained red/blue hsv color mask
//
// drives training samples, class clears and pixels through the request
// channel with random gaps and random result back-pressure. A behavioral
// model of the two class boxes and the margin registers predicts every
// result, and each result is checked field by field in order. The margins
// are reprogrammed between phases, including all-zero and all-ones
// settings, while the block is drained.
// ----------------------------------------------------------------------------
module hsv_sample_trained_color_mask_core_test;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int unsigned MAX_WAIT     = 16;
   localparam int unsigned CYCLE_LIMIT  = 400000;
   localparam int unsigned DRAIN_CYCLES = 4;
   localparam int unsigned PHASE_ITEMS  = 75;
   localparam int unsigned PRINT_LIMIT  = 50;
   localparam int          RED          = 0;
   localparam int          BLUE         = 1;

   // one request transaction plus a flag that makes the sender wait for
   // every outstanding result before presenting it
   typedef struct {
      logic [1:0] op;
      logic [7:0] hue;
      logic [7:0] sat;
      logic [7:0] val;
      bit         hold;
   } hsv_item_type;

   typedef struct packed {
      logic       red;
      logic       blue;
      logic [1:0] outcome;
   } mask_result_type;

   logic       clock;
   logic       reset;
   logic       csr_we;
   logic [1:0] csr_index;
   logic [7:0] csr_wdata;

   hstcm_req_if req_bus ();
   hstcm_rsp_if rsp_bus ();

   hsv_sample_trained_color_mask_core dut (
      .clock     (clock),
      .reset     (reset),
      .req_ch    (req_bus),
      .rsp_ch    (rsp_bus),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   // ---------------------------------------------------------------------
   // clock
   // ---------------------------------------------------------------------
   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // ---------------------------------------------------------------------
   // shared bench state
   // ---------------------------------------------------------------------
   hsv_item_type    pending_items[$];     // transactions waiting to be sent
   mask_result_type expected_results[$];  // predictions for accepted requests

   bit          idle_on;       // random gaps/stalls enabled for this phase
   int unsigned error_count;
   int unsigned cycle_count;
   int unsigned result_count;
   int unsigned pixel_count;
   int unsigned red_hits;
   int unsigned blue_hits;
   int unsigned clear_count;
   int unsigned outcome_count[4];
   int unsigned send_gap;
   int unsigned recv_gap;
   hsv_item_type on_bus;

   // mirror of the trained class boxes, index 0 red, index 1 blue
   logic [7:0] hue_lo[2];
   logic [7:0] hue_hi[2];
   logic [7:0] sat_lo[2];
   logic [7:0] sat_hi[2];
   logic [7:0] val_lo[2];
   logic [7:0] val_hi[2];
   bit         trained[2];

   // mirror of the margin registers
   logic [6:0] red_hue_mrg;
   logic [6:0] blue_hue_mrg;
   logic [7:0] sat_mrg;
   logic [7:0] val_mrg;

   // ---------------------------------------------------------------------
   // mask predictor
   // ---------------------------------------------------------------------
   function automatic void empty_class(int c);
      hue_lo[c]  = 8'hFF;
      hue_hi[c]  = 8'h00;
      sat_lo[c]  = 8'hFF;
      sat_hi[c]  = 8'h00;
      val_lo[c]  = 8'hFF;
      val_hi[c]  = 8'h00;
      trained[c] = 1'b0;
   endfunction

   // grow the class box so it covers the new sample
   function automatic void widen_class(int c, hsv_item_type it);
      if (it.hue < hue_lo[c]) hue_lo[c] = it.hue;
      if (it.hue > hue_hi[c]) hue_hi[c] = it.hue;
      if (it.sat < sat_lo[c]) sat_lo[c] = it.sat;
      if (it.sat > sat_hi[c]) sat_hi[c] = it.sat;
      if (it.val < val_lo[c]) val_lo[c] = it.val;
      if (it.val > val_hi[c]) val_hi[c] = it.val;
      trained[c] = 1'b1;
   endfunction

   // x within [lo - margin, hi + margin], floor at zero, ceiling at top
   function automatic bit within_band(int x, int lo, int hi, int margin, int top);
      int floor_v;
      int ceil_v;
      floor_v = lo - margin;
      if (floor_v < 0) floor_v = 0;
      ceil_v = hi + margin;
      if (ceil_v > top) ceil_v = top;
      return (x >= floor_v) && (x <= ceil_v);
   endfunction

   function automatic bit pixel_hits(int c, int hue_margin, hsv_item_type it);
      return trained[c]
         && within_band(it.hue, hue_lo[c], hue_hi[c], hue_margin, hstcm_pkg::HUE_TOP)
         && within_band(it.sat, sat_lo[c], sat_hi[c], sat_mrg, hstcm_pkg::CHAN_TOP)
         && within_band(it.val, val_lo[c], val_hi[c], val_mrg, hstcm_pkg::CHAN_TOP);
   endfunction

   // computes the result of one accepted request and updates the class boxes
   function automatic mask_result_type predict_mask(hsv_item_type it);
      mask_result_type r;
      r = '0;
      case (it.op)
         hstcm_pkg::OP_PIXEL: begin
            r.red  = pixel_hits(RED, red_hue_mrg, it);
            r.blue = pixel_hits(BLUE, blue_hue_mrg, it);
            pixel_count++;
            red_hits  += r.red;
            blue_hits += r.blue;
         end
         hstcm_pkg::OP_SAMPLE: begin
            // upper red hue segment ends at 180, nothing above 180 trains
            if ((it.hue <= hstcm_pkg::RED_LOW_TOP)
                || ((it.hue >= hstcm_pkg::RED_HIGH_BASE)
                    && (it.hue <= hstcm_pkg::HUE_TOP))) begin
               widen_class(RED, it);
               r.outcome = hstcm_pkg::OUTCOME_RED;
            end else if ((it.hue >= hstcm_pkg::BLUE_BASE)
                         && (it.hue <= hstcm_pkg::BLUE_TOP)) begin
               widen_class(BLUE, it);
               r.outcome = hstcm_pkg::OUTCOME_BLUE;
            end else begin
               r.outcome = hstcm_pkg::OUTCOME_REJECTED;
            end
         end
         hstcm_pkg::OP_CLEAR_RED: begin
            empty_class(RED);
            clear_count++;
         end
         default: begin
            empty_class(BLUE);
            clear_count++;
         end
      endcase
      outcome_count[r.outcome]++;
      return r;
   endfunction

   // ---------------------------------------------------------------------
   // mismatch reporting
   // ---------------------------------------------------------------------
   task automatic report_mismatch(input string msg);
      error_count++;
      if (error_count <= PRINT_LIMIT) begin
         $display("[%0t] ERROR: %s", $realtime, msg);
      end
   endtask

   // ---------------------------------------------------------------------
   // request driver: pops pending transactions, predicts on acceptance
   // ---------------------------------------------------------------------
   always @(posedge clock) begin
      bit took;
      took = req_bus.valid && req_bus.ready;
      if (reset) begin
         req_bus.valid <= 1'b0;
         send_gap = 0;
      end else begin
         if (took) begin
            expected_results.insert(expected_results.size(), predict_mask(on_bus));
         end
         if (!req_bus.valid || took) begin
            if (send_gap > 0) begin
               send_gap--;
               req_bus.valid <= 1'b0;
            end else if (pending_items.size() != 0
                         && !(pending_items[0].hold && expected_results.size() != 0)) begin
               on_bus = pending_items.pop_front();
               req_bus.valid      <= 1'b1;
               req_bus.operation  <= on_bus.op;
               req_bus.hue        <= on_bus.hue;
               req_bus.saturation <= on_bus.sat;
               req_bus.brightness <= on_bus.val;
               send_gap = idle_on ? $urandom_range(0, MAX_WAIT) : 0;
            end else begin
               req_bus.valid <= 1'b0;
            end
         end
      end
   end

   // ---------------------------------------------------------------------
   // result monitor: random back-pressure, in-order compare
   // ---------------------------------------------------------------------
   always @(posedge clock) begin
      bit              got;
      mask_result_type seen;
      mask_result_type want;
      got = rsp_bus.valid && rsp_bus.ready;
      if (reset) begin
         rsp_bus.ready <= 1'b0;
         recv_gap = 0;
      end else begin
         if (got) begin
            seen = {rsp_bus.red_match, rsp_bus.blue_match, rsp_bus.sample_outcome};
            result_count++;
            if (expected_results.size() == 0) begin
               report_mismatch($sformatf("result %0d arrived with nothing expected",
                                         result_count));
            end else begin
               want = expected_results.pop_front();
               if (seen.red !== want.red)
                  report_mismatch($sformatf("result %0d red_match %b, expected %b",
                                            result_count, seen.red, want.red));
               if (seen.blue !== want.blue)
                  report_mismatch($sformatf("result %0d blue_match %b, expected %b",
                                            result_count, seen.blue, want.blue));
               if (seen.outcome !== want.outcome)
                  report_mismatch($sformatf("result %0d sample_outcome %0d, expected %0d",
                                            result_count, seen.outcome, want.outcome));
            end
            recv_gap = idle_on ? $urandom_range(0, MAX_WAIT) : 0;
         end
         if (recv_gap > 0) begin
            recv_gap--;
            rsp_bus.ready <= 1'b0;
         end else begin
            rsp_bus.ready <= 1'b1;
         end
      end
   end

   // ---------------------------------------------------------------------
   // watchdog
   // ---------------------------------------------------------------------
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d results outstanding",
                  cycle_count, expected_results.size());
         $display("hsv_sample_trained_color_mask_core: mismatch");
         $finish;
      end
   end

   // ---------------------------------------------------------------------
   // stimulus helpers
   // ---------------------------------------------------------------------
   task automatic push_item(input logic [1:0] op, input int h, input int s, input int v,
                            input bit hold);
      hsv_item_type it;
      it.op   = op;
      it.hue  = h[7:0];
      it.sat  = s[7:0];
      it.val  = v[7:0];
      it.hold = hold;
      pending_items.insert(pending_items.size(), it);
   endtask

   // random value around a center, clamped to the 8 bit channel range
   function automatic int near(int center, int spread);
      int x;
      x = center + int'($urandom_range(0, 2 * spread)) - spread;
      if (x < 0) x = 0;
      if (x > 255) x = 255;
      return x;
   endfunction

   // register write, only ever issued with the block drained
   task automatic write_margin(input logic [1:0] index, input logic [7:0] value);
      @(posedge clock);
      csr_we    <= 1'b1;
      csr_index <= index;
      csr_wdata <= value;
      case (index)
         hstcm_pkg::REG_RED_HUE_MARGIN:    red_hue_mrg  = value[6:0];
         hstcm_pkg::REG_BLUE_HUE_MARGIN:   blue_hue_mrg = value[6:0];
         hstcm_pkg::REG_SATURATION_MARGIN: sat_mrg      = value;
         default:                          val_mrg      = value;
      endcase
   endtask

   task automatic program_margins(input int r, input int b, input int s, input int v);
      write_margin(hstcm_pkg::REG_RED_HUE_MARGIN, r[7:0]);
      write_margin(hstcm_pkg::REG_BLUE_HUE_MARGIN, b[7:0]);
      write_margin(hstcm_pkg::REG_SATURATION_MARGIN, s[7:0]);
      write_margin(hstcm_pkg::REG_BRIGHTNESS_MARGIN, v[7:0]);
      @(posedge clock);
      csr_we <= 1'b0;
   endtask

   // sampled on the falling edge so the driver's updates have settled
   task automatic wait_drained();
      do @(negedge clock);
      while (pending_items.size() != 0 || req_bus.valid || expected_results.size() != 0);
   endtask

   // ---------------------------------------------------------------------
   // directed part: empty classes, every hue window edge, clears
   // ---------------------------------------------------------------------
   task automatic load_directed();
      push_item(hstcm_pkg::OP_PIXEL, 0, 0, 0, 0);           // empty classes never match
      push_item(hstcm_pkg::OP_PIXEL, 255, 255, 255, 0);
      push_item(hstcm_pkg::OP_SAMPLE, 0, 0, 0, 0);          // red, low hue edge
      push_item(hstcm_pkg::OP_SAMPLE, 20, 255, 255, 0);     // red, top of low segment
      push_item(hstcm_pkg::OP_SAMPLE, 21, 50, 50, 0);       // just above red window
      push_item(hstcm_pkg::OP_SAMPLE, 89, 50, 50, 0);       // just below blue window
      push_item(hstcm_pkg::OP_SAMPLE, 90, 255, 0, 0);       // blue lower edge
      push_item(hstcm_pkg::OP_SAMPLE, 140, 0, 255, 0);      // blue upper edge
      push_item(hstcm_pkg::OP_SAMPLE, 141, 50, 50, 0);
      push_item(hstcm_pkg::OP_SAMPLE, 149, 50, 50, 0);
      push_item(hstcm_pkg::OP_SAMPLE, 150, 128, 128, 0);    // red upper segment
      push_item(hstcm_pkg::OP_SAMPLE, 180, 1, 254, 0);      // hue top
      push_item(hstcm_pkg::OP_SAMPLE, 181, 50, 50, 0);      // past hue top, rejected
      push_item(hstcm_pkg::OP_SAMPLE, 255, 255, 255, 0);
      push_item(hstcm_pkg::OP_PIXEL, 180, 255, 255, 0);     // red box now covers everything
      push_item(hstcm_pkg::OP_PIXEL, 181, 128, 128, 0);     // hue past clamp never matches
      push_item(hstcm_pkg::OP_PIXEL, 255, 0, 0, 0);
      push_item(hstcm_pkg::OP_PIXEL, 115, 128, 128, 0);     // both classes
      push_item(hstcm_pkg::OP_CLEAR_RED, 255, 255, 255, 1); // sender waits for drain here
      push_item(hstcm_pkg::OP_PIXEL, 115, 128, 128, 0);     // blue only
      push_item(hstcm_pkg::OP_CLEAR_BLUE, 0, 0, 0, 0);
      push_item(hstcm_pkg::OP_PIXEL, 100, 100, 100, 0);     // both empty again
      push_item(hstcm_pkg::OP_SAMPLE, 10, 100, 100, 1);
      push_item(hstcm_pkg::OP_PIXEL, 10, 120, 120, 0);      // right on the widened edge
      push_item(hstcm_pkg::OP_PIXEL, 10, 121, 121, 0);      // one past it
   endtask

   // ---------------------------------------------------------------------
   // random part: training clustered around per-phase color centers,
   // pixels mostly near those centers so box edges get exercised
   // ---------------------------------------------------------------------
   task automatic load_random(input int count);
      int center_s[2];
      int center_v[2];
      int spread;
      int pick;
      int c;
      int h;
      bit hold;
      for (int i = 0; i < 2; i++) begin
         center_s[i] = $urandom_range(0, 255);
         center_v[i] = $urandom_range(0, 255);
      end
      spread = $urandom_range(3, 60);
      // fresh boxes for the phase
      push_item(hstcm_pkg::OP_CLEAR_RED, $urandom_range(0, 255), $urandom_range(0, 255),
                $urandom_range(0, 255), 0);
      push_item(hstcm_pkg::OP_CLEAR_BLUE, $urandom_range(0, 255), $urandom_range(0, 255),
                $urandom_range(0, 255), 0);
      for (int k = 0; k < count; k++) begin
         pick = $urandom_range(0, 99);
         hold = ($urandom_range(0, 29) == 0);
         c    = $urandom_range(0, 1);
         if (c == RED) begin
            h = $urandom_range(0, 1) ? $urandom_range(0, 20) : $urandom_range(150, 180);
         end else begin
            h = $urandom_range(90, 140);
         end
         if (pick < 4) begin
            // occasional clear, payload is noise
            push_item($urandom_range(0, 1) ? hstcm_pkg::OP_CLEAR_RED
                                           : hstcm_pkg::OP_CLEAR_BLUE,
                      $urandom_range(0, 255), $urandom_range(0, 255),
                      $urandom_range(0, 255), hold);
         end else if (pick < 32) begin
            // well-formed training sample for one class
            push_item(hstcm_pkg::OP_SAMPLE, h, near(center_s[c], spread),
                      near(center_v[c], spread), hold);
         end else if (pick < 38) begin
            // sample with any hue, mostly rejected ones
            push_item(hstcm_pkg::OP_SAMPLE, $urandom_range(0, 255), $urandom_range(0, 255),
                      $urandom_range(0, 255), hold);
         end else if (pick < 50) begin
            // pixel anywhere
            push_item(hstcm_pkg::OP_PIXEL, $urandom_range(0, 255), $urandom_range(0, 255),
                      $urandom_range(0, 255), hold);
         end else begin
            // pixel near a trained box, often just across an edge
            push_item(hstcm_pkg::OP_PIXEL, near(h, 30), near(center_s[c], 2 * spread + 10),
                      near(center_v[c], 2 * spread + 10), hold);
         end
      end
   endtask

   // ---------------------------------------------------------------------
   // test sequence
   // ---------------------------------------------------------------------
   initial begin
      // known values on every block input before the first edge
      reset              = 1'b1;
      csr_we             = 1'b0;
      csr_index          = hstcm_pkg::REG_RED_HUE_MARGIN;
      csr_wdata          = 8'd0;
      req_bus.valid      = 1'b0;
      req_bus.operation  = hstcm_pkg::OP_PIXEL;
      req_bus.hue        = 8'd0;
      req_bus.saturation = 8'd0;
      req_bus.brightness = 8'd0;
      rsp_bus.ready      = 1'b0;
      idle_on            = 1'b1;

      // predictor starts from the reset state
      red_hue_mrg  = hstcm_pkg::RED_HUE_MARGIN_RST;
      blue_hue_mrg = hstcm_pkg::BLUE_HUE_MARGIN_RST;
      sat_mrg      = hstcm_pkg::SATURATION_MARGIN_RST;
      val_mrg      = hstcm_pkg::BRIGHTNESS_MARGIN_RST;
      empty_class(RED);
      empty_class(BLUE);

      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // directed checks run on the reset margins
      load_directed();
      wait_drained();

      // margins at zero, no idling
      idle_on = 1'b0;
      program_margins(0, 0, 0, 0);
      load_random(PHASE_ITEMS);
      wait_drained();

      // all ones: hue margins past their nominal range
      idle_on = 1'b1;
      program_margins(255, 255, 255, 255);
      load_random(PHASE_ITEMS);
      wait_drained();

      // top of the nominal ranges
      program_margins(90, 90, 255, 255);
      load_random(PHASE_ITEMS);
      wait_drained();

      // small margins, tight boxes, no idling
      idle_on = 1'b0;
      program_margins($urandom_range(0, 15), $urandom_range(0, 15),
                      $urandom_range(0, 15), $urandom_range(0, 15));
      load_random(PHASE_ITEMS);
      wait_drained();

      // fully random margins
      idle_on = 1'b1;
      program_margins($urandom_range(0, 255), $urandom_range(0, 255),
                      $urandom_range(0, 255), $urandom_range(0, 255));
      load_random(PHASE_ITEMS);
      wait_drained();

      // back to the power-up values
      program_margins(hstcm_pkg::RED_HUE_MARGIN_RST, hstcm_pkg::BLUE_HUE_MARGIN_RST,
                      hstcm_pkg::SATURATION_MARGIN_RST, hstcm_pkg::BRIGHTNESS_MARGIN_RST);
      load_random(PHASE_ITEMS);
      wait_drained();

      // let any stray result show up
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (expected_results.size() != 0) begin
         report_mismatch($sformatf("%0d results never arrived", expected_results.size()));
      end

      $display("covered %0d results: %0d pixels (%0d red, %0d blue hits), %0d clears",
               result_count, pixel_count, red_hits, blue_hits, clear_count);
      $display("samples: %0d red, %0d blue, %0d rejected; %0d errors in %0d cycles",
               outcome_count[hstcm_pkg::OUTCOME_RED], outcome_count[hstcm_pkg::OUTCOME_BLUE],
               outcome_count[hstcm_pkg::OUTCOME_REJECTED], error_count, cycle_count);
      if (error_count == 0) begin
         $display("hsv_sample_trained_color_mask_core: match");
      end else begin
         $display("hsv_sample_trained_color_mask_core: mismatch");
      end
      $finish;
   end

endmodule
